// File: src/mmh_pkg.sv
// ----------------------------------------------------------------------------
// mmh_pkg: shared constants and types for the MurmurHash64A stream hasher
// Mixing constant, length reduction and the control/status bundle of the
// shared 64-bit constant multiplier.
// ----------------------------------------------------------------------------
package mmh_pkg;

	localparam logic [63:0] MIX_MUL     = 64'hc6a4a7935bd1e995;
	localparam int unsigned MIX_SHIFT   = 47;
	localparam int unsigned LENGTH_BITS = 32;

	// total_length is reduced to LENGTH_BITS bits before it seeds the hash
	localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LENGTH_BITS);

	// request to the shared multiplier: product op * MIX_MUL mod 2^64
	typedef struct packed {
		logic        start;
		logic [63:0] op;
	} mul_ctl_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [63:0] result;
	} mul_sts_t;

endpackage

// File: src/mmh_word_if.sv
// ----------------------------------------------------------------------------
// mmh_word_if: message word channel
// One beat carries one little-endian 64-bit word of the message.
// ----------------------------------------------------------------------------
interface mmh_word_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  bytes_valid;
	logic        first_word;
	logic        last_word;
	logic [31:0] total_length;

	modport source (
		output valid, data_word, bytes_valid, first_word, last_word, total_length,
		input  ready
	);
	modport sink (
		input  valid, data_word, bytes_valid, first_word, last_word, total_length,
		output ready
	);
endinterface

// File: src/mmh_hash_if.sv
// ----------------------------------------------------------------------------
// mmh_hash_if: hash result channel
// One beat carries the finished 64-bit hash of one message.
// ----------------------------------------------------------------------------
interface mmh_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (
		output valid, hash_value,
		input  ready
	);
	modport sink (
		input  valid, hash_value,
		output ready
	);
endinterface

// File: src/mmh_mul.sv
// ----------------------------------------------------------------------------
// mmh_mul: shared 64-bit multiply by the mixing constant
// Low 64 bits of op * MIX_MUL from one 32x32 multiplier over three steps;
// done pulses in the cycle after the last step, result holds until next start.
// ----------------------------------------------------------------------------
module mmh_mul (
	input  logic              clk,
	input  logic              arst_n,
	input  mmh_pkg::mul_ctl_t ctl,
	output mmh_pkg::mul_sts_t sts
);
	import mmh_pkg::*;

	localparam logic [1:0] STEP_IDLE = 2'd0;
	localparam logic [1:0] STEP_LL   = 2'd1;  // lo(a) * lo(M), full 64 bits
	localparam logic [1:0] STEP_HL   = 2'd2;  // hi(a) * lo(M), into upper half
	localparam logic [1:0] STEP_LH   = 2'd3;  // lo(a) * hi(M), into upper half

	logic [1:0]  step_q;
	logic        done_q;
	logic [63:0] a_q;
	logic [63:0] acc_q;
	logic [31:0] mul_x;
	logic [31:0] mul_y;
	logic [63:0] prod;

	always_comb begin
		case (step_q)
			STEP_HL: begin
				mul_x = a_q[63:32];
				mul_y = MIX_MUL[31:0];
			end
			STEP_LH: begin
				mul_x = a_q[31:0];
				mul_y = MIX_MUL[63:32];
			end
			default: begin
				mul_x = a_q[31:0];
				mul_y = MIX_MUL[31:0];
			end
		endcase
		prod = 64'(mul_x) * 64'(mul_y);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_IDLE;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (step_q)
				STEP_IDLE: begin
					if (ctl.start) step_q <= STEP_LL;
				end
				STEP_LL: step_q <= STEP_HL;
				STEP_HL: step_q <= STEP_LH;
				STEP_LH: begin
					step_q <= STEP_IDLE;
					done_q <= 1'b1;
				end
				default: step_q <= STEP_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step_q == STEP_IDLE && ctl.start) a_q <= ctl.op;
		case (step_q)
			STEP_LL: acc_q <= prod;
			STEP_HL, STEP_LH: acc_q[63:32] <= acc_q[63:32] + prod[31:0];
			default: acc_q <= acc_q;
		endcase
	end

	assign sts.busy   = (step_q != STEP_IDLE);
	assign sts.done   = done_q;
	assign sts.result = acc_q;

endmodule

// File: src/murmur64a_stream_hash.sv
// ----------------------------------------------------------------------------
// murmur64a_stream_hash: MurmurHash64A (seed zero) over a word stream
// Sequencer around one shared constant multiplier, plus a result register.
// ----------------------------------------------------------------------------
// Usage:
//   word_ch carries the message as little-endian 64-bit words, one per beat.
//   first_word on the first beat seeds the hash from total_length; last_word
//   on the final beat (bytes_valid 0..8 there, 8 elsewhere, >8 counts as 8)
//   produces one beat on hash_ch. An empty message is a single beat with
//   both marks set and bytes_valid zero.
//   Every 64-bit multiply goes through mmh_mul: three passes of one 32x32
//   multiplier, then a done pulse. The word channel is held off (ready
//   low) while a word is in flight. Per word: a full word takes three
//   multiplies, a partial word one and an empty word none; first_word adds
//   one for the length seed; last_word adds one for the finish and a load
//   of the result register. The beat itself is taken in idle.
//   Reset clears the running hash to zero, empties the result register and
//   returns to idle. If hash_ch stalls, one finished hash waits in the
//   result register while the next message is taken in; only a second
//   finished hash waits (in the push state) until the register drains.
// ----------------------------------------------------------------------------
module murmur64a_stream_hash (
	input logic       clk,
	input logic       arst_n,
	mmh_word_if.sink  word_ch,
	mmh_hash_if.source hash_ch
);
	import mmh_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word beat
	localparam logic [2:0] S_LEN  = 3'd1;  // h = len * M
	localparam logic [2:0] S_K1   = 3'd2;  // k = word * M
	localparam logic [2:0] S_K2   = 3'd3;  // k = (k ^ k>>47) * M
	localparam logic [2:0] S_H    = 3'd4;  // h = (h ^ k) * M, or (h ^ tail) * M
	localparam logic [2:0] S_FIN  = 3'd5;  // f = (h ^ h>>47) * M
	localparam logic [2:0] S_PUSH = 3'd6;  // wait for room in result register

	logic [2:0]  state_q;
	logic [2:0]  state_nxt;
	logic [63:0] h_q;       // running hash, unfinished
	logic [63:0] h_nxt;
	logic [63:0] word_q;
	logic [3:0]  nb_q;      // saturated byte count, 0..8
	logic        last_q;

	logic [63:0] hash_q;
	logic        ov_q;
	logic        out_load;

	mul_ctl_t    mul_ctl;
	mul_sts_t    mul_sts;

	logic        accept;
	logic [63:0] cur_word;
	logic [3:0]  cur_nb;
	logic        cur_last;
	logic [3:0]  in_nb;
	logic [63:0] cur_h;
	logic [63:0] byte_mask;
	logic [63:0] tail_h;
	logic [63:0] k_mix;
	logic        word_step;
	logic        fin_step;

	mmh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.sts    (mul_sts)
	);

	assign word_ch.ready = (state_q == S_IDLE);
	assign accept        = word_ch.valid && word_ch.ready;

	// counts above 8 saturate
	assign in_nb = (word_ch.bytes_valid > 4'd8) ? 4'd8 : word_ch.bytes_valid;

	// in idle the item is still on the port, later it sits in the registers
	assign cur_word = (state_q == S_IDLE) ? word_ch.data_word : word_q;
	assign cur_nb   = (state_q == S_IDLE) ? in_nb : nb_q;
	assign cur_last = (state_q == S_IDLE) ? word_ch.last_word : last_q;

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			byte_mask[i*8 +: 8] = (4'(i) < cur_nb) ? 8'hff : 8'h00;
		end
	end

	assign k_mix = mul_sts.result ^ (mul_sts.result >> MIX_SHIFT);

	always_comb begin
		state_nxt   = state_q;
		h_nxt       = h_q;
		mul_ctl     = '0;
		out_load    = 1'b0;
		cur_h       = h_q;
		word_step   = 1'b0;
		fin_step    = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (word_ch.first_word) begin
						mul_ctl.start = 1'b1;
						mul_ctl.op    = {32'd0, word_ch.total_length} & LEN_MASK;
						state_nxt     = S_LEN;
					end else begin
						word_step = 1'b1;
					end
				end
			end
			S_LEN: begin
				if (mul_sts.done) begin
					cur_h     = mul_sts.result;
					h_nxt     = mul_sts.result;
					word_step = 1'b1;
				end
			end
			S_K1: begin
				if (mul_sts.done) begin
					mul_ctl.start = 1'b1;
					mul_ctl.op    = k_mix;
					state_nxt     = S_K2;
				end
			end
			S_K2: begin
				if (mul_sts.done) begin
					h_nxt         = h_q ^ mul_sts.result;
					mul_ctl.start = 1'b1;
					mul_ctl.op    = h_q ^ mul_sts.result;
					state_nxt     = S_H;
				end
			end
			S_H: begin
				if (mul_sts.done) begin
					cur_h    = mul_sts.result;
					h_nxt    = mul_sts.result;
					fin_step = 1'b1;
				end
			end
			S_FIN: begin
				if (mul_sts.done) state_nxt = S_PUSH;
			end
			S_PUSH: begin
				// multiplier result holds until the next start
				if (!ov_q || hash_ch.ready) begin
					out_load  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: state_nxt = S_IDLE;
		endcase

		tail_h = cur_h ^ (cur_word & byte_mask);

		if (word_step) begin
			if (cur_nb == 4'd8) begin
				mul_ctl.start = 1'b1;
				mul_ctl.op    = cur_word;
				state_nxt     = S_K1;
			end else if (cur_nb != 4'd0) begin
				h_nxt         = tail_h;
				mul_ctl.start = 1'b1;
				mul_ctl.op    = tail_h;
				state_nxt     = S_H;
			end else begin
				fin_step = 1'b1;  // empty word: nothing folded in
			end
		end

		if (fin_step) begin
			if (cur_last) begin
				mul_ctl.start = 1'b1;
				mul_ctl.op    = cur_h ^ (cur_h >> MIX_SHIFT);
				state_nxt     = S_FIN;
			end else begin
				state_nxt = S_IDLE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			h_q     <= '0;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_nxt;
			h_q     <= h_nxt;
			if (out_load)           ov_q <= 1'b1;
			else if (hash_ch.ready) ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= word_ch.data_word;
			nb_q   <= in_nb;
			last_q <= word_ch.last_word;
		end
		if (out_load) hash_q <= k_mix;
	end

	assign hash_ch.valid      = ov_q;
	assign hash_ch.hash_value = hash_q;

`ifndef SYNTHESIS
	// the sequencer never issues a multiply while one is in flight
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		mul_ctl.start |-> !mul_sts.busy)
		else $error("multiply started while unit busy");

	// multiply-waiting states always have a multiply running or finishing
	a_mul_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_LEN || state_q == S_K1 || state_q == S_K2 ||
		 state_q == S_H || state_q == S_FIN) |-> (mul_sts.busy || mul_sts.done))
		else $error("sequencer waiting on an idle multiplier");

	// a finished hash is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !hash_ch.ready) |=> (ov_q && $stable(hash_q)))
		else $error("pending hash lost");
`endif

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the MurmurHash64A word-stream hasher
// Feeds message words through a queue-fed driver and checks every finished
// hash against an in-bench predictor, under random idling and backpressure.
// ----------------------------------------------------------------------------
module tb_top;
	import mmh_pkg::*;

	// Four traffic phases split the random words evenly.
	localparam int unsigned PHASE_WORDS     = 455;
	// One long receiver hold-off; long enough to fill the result register
	// and the push state, so the block has to drop ready on the word side.
	localparam int unsigned HOLD_OFF_CYCLES = 400;
	// Cycles with nothing moving on either channel before the run is
	// declared hung; well above the hold-off and any random stall run.
	localparam int unsigned WATCHDOG_LIMIT  = 4000;
	// Quiet time after the last hash, longer than a one-word message takes.
	localparam int unsigned DRAIN_CYCLES    = 40;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  bytes_valid;
		logic        first_word;
		logic        last_word;
		logic [31:0] total_length;
	} word_beat_t;

	logic clk;
	logic arst_n;

	mmh_word_if word_ch ();
	mmh_hash_if hash_ch ();

	murmur64a_stream_hash dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.word_ch (word_ch),
		.hash_ch (hash_ch)
	);

	// ------------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------------
	word_beat_t  word_queue[$];       // beats waiting for the driver
	logic [63:0] expected_hashes[$];  // finished hashes not yet seen on hash_ch
	logic [63:0] hash_state = '0;     // predictor copy of the running hash

	int unsigned sender_idle_pct    = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned beats_offered      = 0;  // beats put on word_ch by the driver
	int unsigned beats_accepted     = 0;  // beats taken by the block
	int unsigned words_queued       = 0;
	int unsigned quiet_cycles       = 0;
	int unsigned error_count        = 0;
	int unsigned hold_left          = 0;
	bit          pressure_armed     = 1'b0;
	bit          pressure_served    = 1'b0;

	// ------------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------------
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ------------------------------------------------------------------------
	// predictor: folds one accepted beat into hash_state; a last_word beat
	// also queues the finished hash
	// ------------------------------------------------------------------------
	function automatic void absorb_word(input logic [63:0] data, input logic [3:0] nbytes,
			input logic first, input logic last, input logic [31:0] claimed);
		logic [63:0] h;
		logic [63:0] k;
		logic [63:0] keep_mask;
		int unsigned count;
		// first beat reseeds from the length; otherwise carry on from
		// whatever is left, even the unfinished hash of an old message
		h = first ? ((64'(claimed) & LEN_MASK) * MIX_MUL) : hash_state;
		// counts above 8 saturate
		count = (nbytes > 4'd8) ? 8 : int'(nbytes);
		if (count == 8) begin
			k = data * MIX_MUL;
			k = k ^ (k >> MIX_SHIFT);
			k = k * MIX_MUL;
			h = (h ^ k) * MIX_MUL;
		end else if (count != 0) begin
			// tail word: bytes past the count are garbage and must be dropped
			keep_mask = (64'd1 << (8 * count)) - 64'd1;
			h = (h ^ (data & keep_mask)) * MIX_MUL;
		end
		hash_state = h;
		if (last) begin
			h = h ^ (h >> MIX_SHIFT);
			h = h * MIX_MUL;
			expected_hashes.push_back(h ^ (h >> MIX_SHIFT));
		end
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic push_word(input logic [63:0] data, input logic [3:0] nbytes,
			input logic first, input logic last, input logic [31:0] claimed);
		word_queue.push_back('{data, nbytes, first, last, claimed});
		words_queued++;
	endtask

	// Splits a message of nbytes into words. The marks can be dropped to
	// build broken sequences; ragged scrambles the counts of inner words.
	task automatic push_message(input int unsigned nbytes, input logic [31:0] claimed,
			input bit mark_first, input bit mark_last, input bit ragged);
		int unsigned nwords;
		int unsigned tail;
		logic [3:0]  count;
		if (nbytes == 0) begin
			push_word({$urandom, $urandom}, 4'd0, mark_first, mark_last, claimed);
			return;
		end
		nwords = (nbytes + 7) / 8;
		tail   = nbytes - 8 * (nwords - 1);
		for (int unsigned i = 0; i < nwords; i++) begin
			count = (i == nwords - 1) ? 4'(tail) : 4'd8;
			if (ragged && i != nwords - 1 && $urandom_range(0, 2) == 0)
				count = 4'($urandom_range(0, 15));
			push_word({$urandom, $urandom}, count, mark_first && i == 0,
				mark_last && i == nwords - 1, claimed);
		end
	endtask

	// ------------------------------------------------------------------------
	// word driver: changes word_ch on the falling edge; a new beat goes up
	// only once the previous one has been counted as accepted
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		word_beat_t beat;
		if (arst_n && beats_accepted == beats_offered) begin
			if (word_queue.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
				beat = word_queue.pop_front();
				word_ch.data_word    <= beat.data_word;
				word_ch.bytes_valid  <= beat.bytes_valid;
				word_ch.first_word   <= beat.first_word;
				word_ch.last_word    <= beat.last_word;
				word_ch.total_length <= beat.total_length;
				word_ch.valid        <= 1'b1;
				beats_offered++;
			end else begin
				word_ch.valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// hash receiver: random stalls, plus one long hold-off once armed
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (pressure_armed && !pressure_served) begin
				pressure_served = 1'b1;
				hold_left       = HOLD_OFF_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				hash_ch.ready <= 1'b0;
			end else begin
				hash_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: samples both channels on the rising edge, checks hashes in
	// order, feeds accepted words to the predictor, and runs the watchdog
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		logic [63:0] want;
		bit          moved;
		if (arst_n) begin
			moved = 1'b0;
			// check the output first: a hash can never come from a word
			// taken on the same edge
			if (hash_ch.valid && hash_ch.ready) begin
				moved = 1'b1;
				if (expected_hashes.size() == 0) begin
					error_count++;
					$error("hash_value: expected none, actual %h", hash_ch.hash_value);
				end else begin
					want = expected_hashes.pop_front();
					if (hash_ch.hash_value !== want) begin
						error_count++;
						$error("hash_value: expected %h, actual %h", want, hash_ch.hash_value);
					end
				end
			end
			if (word_ch.valid && word_ch.ready) begin
				moved = 1'b1;
				beats_accepted++;
				absorb_word(word_ch.data_word, word_ch.bytes_valid, word_ch.first_word,
					word_ch.last_word, word_ch.total_length);
			end
			// only count quiet cycles while something is still owed
			if (moved || (word_queue.size() == 0 && beats_accepted == beats_offered &&
					expected_hashes.size() == 0))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("[murmur64a_stream_hash] ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	initial begin
		int unsigned pick;
		int unsigned nbytes;

		arst_n               = 1'b0;
		word_ch.valid        = 1'b0;
		word_ch.data_word    = '0;
		word_ch.bytes_valid  = '0;
		word_ch.first_word   = 1'b0;
		word_ch.last_word    = 1'b0;
		word_ch.total_length = '0;
		hash_ch.ready        = 1'b0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed beats, no idling
		// no first mark straight out of reset: continues from a zero hash
		push_word({$urandom, $urandom}, 4'd8, 1'b0, 1'b1, 32'd0);
		// again without a first mark: picks up the unfinished hash left behind
		push_word({$urandom, $urandom}, 4'd5, 1'b0, 1'b1, 32'd0);
		// empty messages, zero and largest length
		push_word('0, 4'd0, 1'b1, 1'b1, 32'd0);
		push_word('1, 4'd0, 1'b1, 1'b1, 32'hffff_ffff);
		// single full words, all ones and all zeros
		push_word('1, 4'd8, 1'b1, 1'b1, 32'd8);
		push_word('0, 4'd8, 1'b1, 1'b1, 32'd8);
		// every tail size; all-ones data exposes any masking slip
		for (int unsigned n = 1; n < 8; n++)
			push_word('1, 4'(n), 1'b1, 1'b1, 32'(n));
		// oversized byte counts saturate to a full word
		push_word({$urandom, $urandom}, 4'd9, 1'b1, 1'b1, 32'd8);
		push_word({$urandom, $urandom}, 4'd15, 1'b1, 1'b1, 32'd8);
		// empty word in the middle of a message
		push_word({$urandom, $urandom}, 4'd8, 1'b1, 1'b0, 32'd11);
		push_word({$urandom, $urandom}, 4'd0, 1'b0, 1'b0, 32'd0);
		push_word({$urandom, $urandom}, 4'd3, 1'b0, 1'b1, 32'd0);
		// partial word that is not last
		push_word({$urandom, $urandom}, 4'd3, 1'b1, 1'b0, 32'd19);
		push_word({$urandom, $urandom}, 4'd8, 1'b0, 1'b0, 32'd0);
		push_word({$urandom, $urandom}, 4'd8, 1'b0, 1'b1, 32'd0);
		// length that disagrees with the words sent
		push_word({$urandom, $urandom}, 4'd8, 1'b1, 1'b1, 32'h0001_2345);
		// last beat with no bytes and no first mark: finish of the carried hash
		push_word({$urandom, $urandom}, 4'd0, 1'b0, 1'b1, 32'd0);

		// random phases: free flow, slow sender, slow receiver, both
		for (int unsigned phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
					pressure_armed     = 1'b1;  // sender keeps offering meanwhile
				end
				1: begin
					sender_idle_pct    = 71;
					receiver_stall_pct = 0;
				end
				2: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 71;
				end
				default: begin
					sender_idle_pct    = 19;
					receiver_stall_pct = 19;
				end
			endcase
			while (words_queued < 23 + (phase + 1) * PHASE_WORDS) begin
				pick = $urandom_range(0, 99);
				// mostly short messages, now and then a long one
				nbytes = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 160)
					: $urandom_range(0, 40);
				if (pick < 80)
					push_message(nbytes, 32'(nbytes), 1'b1, 1'b1, 1'b0);
				else if (pick < 84)
					push_message(nbytes, $urandom, 1'b1, 1'b1, 1'b0);
				else if (pick < 89)
					push_message(nbytes, 32'(nbytes), 1'b0, 1'b1, 1'b0);
				else if (pick < 93)
					push_message(nbytes, 32'(nbytes), 1'b1, 1'b0, 1'b0);
				else if (pick < 97)
					push_message(nbytes, 32'(nbytes), 1'b1, 1'b1, 1'b1);
				else
					push_word({$urandom, $urandom}, 4'($urandom_range(0, 15)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom);
			end
			while (word_queue.size() != 0)
				@(posedge clk);
		end

		// wind down: let the last hashes out with no stalls
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		while (beats_accepted != beats_offered)
			@(posedge clk);
		while (expected_hashes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("[murmur64a_stream_hash] OK");
		else
			$display("[murmur64a_stream_hash] ERROR");
		$finish;
	end

endmodule

// File: sim.f
src/mmh_pkg.sv
src/mmh_word_if.sv
src/mmh_hash_if.sv
src/mmh_mul.sv
src/murmur64a_stream_hash.sv
tb/tb_top.sv
